// ===== hdl/itpa_pkg.sv =====
// Shared types, constants and helpers of the padded ASCII integer formatter.
`timescale 1ns / 1ps
`default_nettype none
package itpa_pkg;

  localparam int VALUE_BITS_DEF = 32;
  localparam int MAX_OUT        = 64;

  localparam int FLAG_ZEROPAD = 0;
  localparam int FLAG_SIGNED  = 1;
  localparam int FLAG_PLUS    = 2;
  localparam int FLAG_SPACE   = 3;
  localparam int FLAG_LEFT    = 4;
  localparam int FLAG_PREFIX  = 5;
  localparam int FLAG_LOWER   = 6;

  localparam logic [5:0] BASE_MIN = 6'd2;
  localparam logic [5:0] BASE_MAX = 6'd36;
  localparam logic [5:0] BASE_OCT = 6'd8;
  localparam logic [5:0] BASE_HEX = 6'd16;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_UP_A  = 8'h41;
  localparam logic [7:0] CH_LO_A  = 8'h61;
  localparam logic [7:0] CH_NONE  = 8'h00;

  typedef struct packed {
    logic [31:0] value;
    logic [5:0]  base;
    logic [5:0]  width;
    logic [5:0]  precision;
    logic [6:0]  flags;
  } in_word_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last;
    logic       bad_base;
  } out_word_t;

  typedef struct packed {
    logic        bad;
    logic [7:0]  sign_char;
    logic [31:0] mag;
    logic [5:0]  base;
    logic [5:0]  width;
    logic [5:0]  prec;
    logic        zeropad;
    logic        left;
    logic [1:0]  pfx_len;
    logic        lower;
  } job_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_PLAN,
    ST_EMIT
  } back_state_t;

  function automatic logic [7:0] digit_char(input logic [5:0] d, input logic lower);
    logic [7:0] d8;
    d8 = {2'b00, d};
    if (d < 6'd10) begin
      return CH_ZERO + d8;
    end
    return (lower ? CH_LO_A : CH_UP_A) + d8 - 8'd10;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/itpa_front.sv =====
// Front end: classifies an incoming word into a formatting job.
`timescale 1ns / 1ps
`default_nettype none
module itpa_front
  import itpa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  in_word_t in_word,
  output job_t     job
);

  logic [VALUE_BITS-1:0] v;
  logic                  neg;
  logic [VALUE_BITS-1:0] m;
  logic                  left;

  always_comb begin
    v    = in_word.value[VALUE_BITS-1:0];
    neg  = in_word.flags[FLAG_SIGNED] && v[VALUE_BITS-1];
    m    = neg ? (~v + 1'b1) : v;
    left = in_word.flags[FLAG_LEFT];

    job.bad       = (in_word.base < BASE_MIN) || (in_word.base > BASE_MAX);
    job.mag       = 32'(m);
    job.base      = in_word.base;
    job.width     = in_word.width;
    job.prec      = in_word.precision;
    job.zeropad   = in_word.flags[FLAG_ZEROPAD] && !left;
    job.left      = left;
    job.lower     = in_word.flags[FLAG_LOWER];

    if (neg) begin
      job.sign_char = CH_MINUS;
    end else if (in_word.flags[FLAG_PLUS]) begin
      job.sign_char = CH_PLUS;
    end else if (in_word.flags[FLAG_SPACE]) begin
      job.sign_char = CH_SPACE;
    end else begin
      job.sign_char = CH_NONE;
    end

    if (!in_word.flags[FLAG_PREFIX]) begin
      job.pfx_len = 2'd0;
    end else if (in_word.base == BASE_OCT) begin
      job.pfx_len = 2'd1;
    end else if (in_word.base == BASE_HEX) begin
      job.pfx_len = 2'd2;
    end else begin
      job.pfx_len = 2'd0;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/itpa_queue.sv =====
// Two-entry job queue between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module itpa_queue
  import itpa_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic q_push,
  input  job_t q_din,
  output logic q_full,
  input  logic q_pop,
  output job_t q_dout,
  output logic q_empty
);

  job_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  always_comb begin
    q_full     = (count_r == 2'd2);
    q_empty    = (count_r == 2'd0);
    q_dout     = mem_r[rd_ptr_r];
    do_push    = q_push && !q_full;
    do_pop     = q_pop && !q_empty;
    wr_ptr_nxt = wr_ptr_r ^ do_push;
    rd_ptr_nxt = rd_ptr_r ^ do_pop;
    count_nxt  = count_r + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= q_din;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/itpa_back.sv =====
// Back end: radix conversion by iterative division, layout and character output.
`timescale 1ns / 1ps
`default_nettype none
module itpa_back
  import itpa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  job_t      q_job,
  input  logic      q_empty,
  output logic      q_pop,
  output out_word_t out_word,
  output logic      empty,
  input  logic      pop
);

  localparam int DIV_W   = ((VALUE_BITS + 7) / 8) * 8;
  localparam int CHUNKS  = DIV_W / 8;
  localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
  localparam int IDX_W   = $clog2(VALUE_BITS);
  localparam int ND_W    = $clog2(VALUE_BITS + 1);

  back_state_t        state_r, state_nxt;
  job_t               job_r, job_nxt;
  logic [DIV_W-1:0]   work_r, work_nxt;
  logic [5:0]         rem_r, rem_nxt;
  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  logic [ND_W-1:0]    nd_r, nd_nxt;
  logic [5:0]         digs_r [VALUE_BITS];
  logic               dig_we;
  logic [7:0]         b1_r, b2_r, b3_r, b5_r, b6_r, n_r;
  logic [7:0]         b1_nxt, b2_nxt, b3_nxt, b4_nxt, b5_nxt, b6_nxt, n_nxt;
  logic [5:0]         pos_r, pos_nxt;
  out_word_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [DIV_W-1:0]   div_work;
  logic [5:0]         div_rem;
  logic [7:0]         div_top;
  logic [7:0]         div_q;
  logic [6:0]         div_t;

  logic [5:0]         nd6, prec_e;
  logic               has_sign;
  logic [8:0]         pad9;
  logic [7:0]         padp, lead, zfill, trail, len;

  logic               ready;
  logic [7:0]         pos8;
  logic [IDX_W-1:0]   dig_idx;
  out_word_t          word;

  always_comb begin
    div_top = work_r[DIV_W-1 -: 8];
    div_rem = rem_r;
    div_q   = 8'd0;
    div_t   = 7'd0;
    for (int i = 7; i >= 0; i--) begin
      div_t = {div_rem, div_top[i]};
      if (div_t >= {1'b0, job_r.base}) begin
        div_q[i] = 1'b1;
        div_rem  = 6'(div_t - {1'b0, job_r.base});
      end else begin
        div_rem  = div_t[5:0];
      end
    end
    div_work = (work_r << 8) | DIV_W'(div_q);
  end

  always_comb begin
    nd6      = 6'(nd_r);
    prec_e   = (nd6 > job_r.prec) ? nd6 : job_r.prec;
    has_sign = (job_r.sign_char != CH_NONE);
    pad9     = 9'(job_r.width) - 9'(has_sign) - 9'(prec_e);
    padp     = pad9[8] ? 8'd0 : pad9[7:0];
    lead     = (!job_r.zeropad && !job_r.left) ? padp : 8'd0;
    zfill    = job_r.zeropad ? padp : 8'd0;
    trail    = job_r.left ? padp : 8'd0;
    b1_nxt   = lead;
    b2_nxt   = b1_nxt + 8'(has_sign);
    b3_nxt   = b2_nxt + 8'(job_r.pfx_len);
    b4_nxt   = b3_nxt + zfill;
    b5_nxt   = b4_nxt + 8'(prec_e - nd6);
    b6_nxt   = b5_nxt + 8'(nd6);
    len      = b6_nxt + trail;
    n_nxt    = (len > 8'(MAX_OUT)) ? 8'(MAX_OUT) : len;
  end

  always_comb begin
    pos8          = 8'(pos_r);
    dig_idx       = IDX_W'(b6_r - 8'd1 - pos8);
    word.bad_base = 1'b0;
    word.last     = (pos8 == n_r - 8'd1);
    if (pos8 < b1_r) begin
      word.out_char = CH_SPACE;
    end else if (pos8 < b2_r) begin
      word.out_char = job_r.sign_char;
    end else if (pos8 < b3_r) begin
      word.out_char = (pos8 == b2_r) ? CH_ZERO : digit_char(6'd33, job_r.lower);
    end else if (pos8 < b5_r) begin
      word.out_char = CH_ZERO;
    end else if (pos8 < b6_r) begin
      word.out_char = digit_char(digs_r[dig_idx], job_r.lower);
    end else begin
      word.out_char = CH_SPACE;
    end
    if (job_r.bad) begin
      word.out_char = CH_NONE;
      word.last     = 1'b1;
      word.bad_base = 1'b1;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    work_nxt      = work_r;
    rem_nxt       = rem_r;
    chunk_nxt     = chunk_r;
    nd_nxt        = nd_r;
    pos_nxt       = pos_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    q_pop         = 1'b0;
    dig_we        = 1'b0;
    ready         = !out_valid_r || pop;

    if (pop && out_valid_r) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          job_nxt   = q_job;
          work_nxt  = DIV_W'(q_job.mag);
          rem_nxt   = 6'd0;
          chunk_nxt = '0;
          nd_nxt    = '0;
          pos_nxt   = 6'd0;
          state_nxt = q_job.bad ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        work_nxt  = div_work;
        rem_nxt   = div_rem;
        chunk_nxt = chunk_r + 1'b1;
        if (chunk_r == CHUNK_W'(CHUNKS - 1)) begin
          dig_we    = 1'b1;
          nd_nxt    = nd_r + 1'b1;
          chunk_nxt = '0;
          rem_nxt   = 6'd0;
          if (div_work == '0) begin
            state_nxt = ST_PLAN;
          end
        end
      end
      ST_PLAN: begin
        state_nxt = ST_EMIT;
      end
      ST_EMIT: begin
        if (ready) begin
          out_nxt       = word;
          out_valid_nxt = 1'b1;
          pos_nxt       = pos_r + 1'b1;
          if (word.last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    work_r  <= work_nxt;
    rem_r   <= rem_nxt;
    chunk_r <= chunk_nxt;
    nd_r    <= nd_nxt;
    pos_r   <= pos_nxt;
    out_r   <= out_nxt;
    if (state_r == ST_PLAN) begin
      b1_r <= b1_nxt;
      b2_r <= b2_nxt;
      b3_r <= b3_nxt;
      b5_r <= b5_nxt;
      b6_r <= b6_nxt;
      n_r  <= n_nxt;
    end
    if (dig_we) begin
      digs_r[nd_r[IDX_W-1:0]] <= div_rem;
    end
  end

  assign out_word = out_r;
  assign empty    = !out_valid_r;

  a_digit_room: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == ST_DIV |-> nd_r < ND_W'(VALUE_BITS))
    else $error("digit count overran the digit store");

  a_bad_word: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.bad_base) |-> (out_r.last && out_r.out_char == CH_NONE))
    else $error("bad-base word not a lone terminating word");

  a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT && ready && word.last) |=> state_r == ST_IDLE)
    else $error("sequencer did not return to idle after the final word");

  a_no_pop_busy: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> state_r == ST_IDLE)
    else $error("job taken while a job is in progress");

endmodule
`default_nettype wire

// ===== hdl/integer_to_padded_ascii.sv =====
// Top level of the printf-style padded ASCII integer formatter.
//
// Usage:
//   Input side is a queue: present in_word and raise push; a word is taken
//   at a clock edge with push high and full low. Each word carries a value,
//   radix, field width, minimum digit count and flag bits.
//   Result side is a queue: while empty is low, out_word holds the oldest
//   character; raise pop to take it. The final character of a number has
//   last set. An invalid radix yields one word with bad_base and last set.
//   Up to two classified jobs wait between the front and back ends, so new
//   words are taken while earlier text is still going out.
//   A number yields at most 64 characters. The back-end divider retires
//   eight quotient bits per cycle, and the output register delivers one
//   character per cycle while the receiver keeps popping. An invalid radix
//   skips the division and layout steps and goes straight to output.
//   When the receiver stalls, the output register holds and the back end
//   waits; the queue then fills and full rises.
//   Reset (rst_n low, synchronous) empties the queue and the output register.
`timescale 1ns / 1ps
`default_nettype none
module integer_to_padded_ascii
  import itpa_pkg::*;
#(
  parameter int VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      push,
  input  in_word_t  in_word,
  output logic      full,
  output logic      empty,
  input  logic      pop,
  output out_word_t out_word
);

  job_t front_job;
  job_t q_job;
  logic q_pop;
  logic q_empty;

  itpa_front #(
    .VALUE_BITS(VALUE_BITS)
  ) u_front (
    .in_word(in_word),
    .job    (front_job)
  );

  itpa_queue u_queue (
    .clk    (clk),
    .rst_n  (rst_n),
    .q_push (push),
    .q_din  (front_job),
    .q_full (full),
    .q_pop  (q_pop),
    .q_dout (q_job),
    .q_empty(q_empty)
  );

  itpa_back #(
    .VALUE_BITS(VALUE_BITS)
  ) u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .q_job   (q_job),
    .q_empty (q_empty),
    .q_pop   (q_pop),
    .out_word(out_word),
    .empty   (empty),
    .pop     (pop)
  );

endmodule
`default_nettype wire
